// ===== rtl/chunky_to_planar_encoder_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the chunky-to-planar encoder.
// Builds with ASSERT_OFF defined get empty macros.
// ---------------------------------------------------------------------------
`ifndef CHUNKY_TO_PLANAR_ENCODER_TOP_ASSERT_SVH
`define CHUNKY_TO_PLANAR_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define C2P_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
`define C2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`define C2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define C2P_ASSERT(lbl, clk, rst_n, prop)
`define C2P_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define C2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/c2p_pkg.sv =====
// ---------------------------------------------------------------------------
// c2p_pkg
// Shared types and constants of the chunky-to-planar encoder.
// ---------------------------------------------------------------------------
package c2p_pkg;

  localparam int PIX_W    = 8;
  localparam int WORD_W   = 16;
  localparam int PLANE_W  = 3;
  localparam int ROW_W    = 10;
  localparam int WPOS_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Group queue depth between the front and the back.
  localparam int Q_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd2;

  localparam logic [3:0]  PLANES_RST = 4'd4;
  localparam logic [10:0] WIDTH_RST  = 11'd320;
  localparam logic [10:0] ROWS_RST   = 11'd256;

  // Description of one completed group of plane words.
  typedef struct packed {
    logic [PLANE_W-1:0] last_plane;
    logic [ROW_W-1:0]   row;
    logic [WPOS_W-1:0]  word;
    logic               frame_end;
  } c2p_tag_t;

endpackage

// ===== rtl/c2p_ifs.sv =====
// ---------------------------------------------------------------------------
// c2p channel interfaces
// Pixel input, plane word output and register write channels.
// ---------------------------------------------------------------------------
interface c2p_pixel_if import c2p_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_index;
  modport source (output valid, output pixel_index, input ready);
  modport sink   (input valid, input pixel_index, output ready);
endinterface

interface c2p_word_if import c2p_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  plane_word;
  logic [PLANE_W-1:0] plane_number;
  logic [ROW_W-1:0]   row_number;
  logic [WPOS_W-1:0]  word_in_row;
  logic               last_of_group;
  logic               frame_done;
  modport source (output valid, output plane_word, output plane_number,
                  output row_number, output word_in_row, output last_of_group,
                  output frame_done, input ready);
  modport sink   (input valid, input plane_word, input plane_number,
                  input row_number, input word_in_row, input last_of_group,
                  input frame_done, output ready);
endinterface

interface c2p_cfg_if import c2p_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/c2p_front.sv =====
// ---------------------------------------------------------------------------
// c2p_front
// Holds the registers, clamps each pixel, shifts its bits into the plane
// accumulators and hands every completed group to the queue.
// ---------------------------------------------------------------------------
module c2p_front import c2p_pkg::*; #(
  parameter int MAX_PLANES = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  c2p_pixel_if.sink                       in_px,
  c2p_cfg_if.sink                         cfg_wr,
  input  logic                            q_full,
  output logic                            push_valid,
  output logic [MAX_PLANES-1:0][WORD_W-1:0] push_words,
  output c2p_tag_t                        push_tag
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RCW = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;

  logic [3:0]  planes_r;
  logic [10:0] width_r;
  logic [10:0] rows_r;

  logic [MAX_PLANES-1:0][WORD_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [3:0]     planes_eff;
  logic [WCW-1:0] width_ext, width_eff, col_inc;
  logic [RCW-1:0] rows_ext, rows_eff, row_inc;
  logic [8:0]     one_sh;
  logic [PIX_W-1:0] idx_mask, idx_clamped;
  logic [WORD_W-1:0] bit_sel;
  logic [MAX_PLANES-1:0][WORD_W-1:0] acc_hit;
  logic end_row, end_frame, emit_now, in_fire, cfg_hit;

  // Effective limits; zero acts as one and large values saturate.
  always_comb begin
    if (planes_r == 4'd0) begin
      planes_eff = 4'd1;
    end else if (planes_r > 4'(MAX_PLANES)) begin
      planes_eff = 4'(MAX_PLANES);
    end else begin
      planes_eff = planes_r;
    end
    width_ext = WCW'(width_r);
    if (width_ext == '0) begin
      width_eff = WCW'(1);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      width_eff = WCW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    rows_ext = RCW'(rows_r);
    if (rows_ext == '0) begin
      rows_eff = RCW'(1);
    end else if (rows_ext > RCW'(MAX_HEIGHT)) begin
      rows_eff = RCW'(MAX_HEIGHT);
    end else begin
      rows_eff = rows_ext;
    end
  end

  assign col_inc   = WCW'(col_r) + WCW'(1);
  assign row_inc   = RCW'(row_r) + RCW'(1);
  assign end_row   = col_inc >= width_eff;
  assign end_frame = end_row && (row_inc >= rows_eff);
  assign emit_now  = end_row || (col_inc[3:0] == 4'd0);

  // An index above the plane range saturates to all ones in that range.
  assign one_sh      = 9'd1 << planes_eff;
  assign idx_mask    = PIX_W'(one_sh - 9'd1);
  assign idx_clamped = ((in_px.pixel_index & ~idx_mask) != '0) ? idx_mask
                                                                : (in_px.pixel_index & idx_mask);
  assign bit_sel     = 16'h8000 >> col_r[3:0];

  for (genvar p = 0; p < MAX_PLANES; p++) begin : g_acc
    assign acc_hit[p] = acc_r[p] | (idx_clamped[p] ? bit_sel : '0);
  end

  assign in_px.ready = !(emit_now && q_full);
  assign cfg_wr.ready = 1'b1;
  assign in_fire = in_px.valid && in_px.ready;
  assign cfg_hit = cfg_wr.valid && (cfg_wr.index == REG_PLANE_COUNT ||
                                    cfg_wr.index == REG_ROW_WIDTH ||
                                    cfg_wr.index == REG_IMAGE_ROWS);

  assign push_valid          = in_fire && emit_now;
  assign push_words          = acc_hit;
  assign push_tag.last_plane = PLANE_W'(planes_eff - 4'd1);
  assign push_tag.row        = ROW_W'(row_r);
  assign push_tag.word       = WPOS_W'(col_r >> 4);
  assign push_tag.frame_end  = end_frame;

  always_comb begin
    acc_nxt = acc_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      acc_nxt = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      acc_nxt = emit_now ? '0 : acc_hit;
      if (end_row) begin
        col_nxt = '0;
        row_nxt = end_frame ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= PLANES_RST;
      width_r  <= WIDTH_RST;
      rows_r   <= ROWS_RST;
      acc_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      acc_r <= acc_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_PLANE_COUNT: planes_r <= cfg_wr.data[3:0];
          REG_ROW_WIDTH:   width_r  <= cfg_wr.data;
          REG_IMAGE_ROWS:  rows_r   <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/c2p_queue.sv =====
// ---------------------------------------------------------------------------
// c2p_queue
// Short queue of completed groups between the front and the back.
// ---------------------------------------------------------------------------
module c2p_queue import c2p_pkg::*; #(
  parameter int MAX_PLANES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push_valid,
  input  logic [MAX_PLANES-1:0][WORD_W-1:0] push_words,
  input  c2p_tag_t                          push_tag,
  input  logic                              pop,
  output logic                              full,
  output logic                              empty,
  output logic [MAX_PLANES-1:0][WORD_W-1:0] head_words,
  output c2p_tag_t                          head_tag
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [MAX_PLANES-1:0][WORD_W-1:0] words_r [Q_DEPTH];
  c2p_tag_t                          tag_r   [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = count_r == CNT_W'(Q_DEPTH);
  assign empty      = count_r == '0;
  assign head_words = words_r[rd_ptr_r];
  assign head_tag   = tag_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      words_r[wr_ptr_r] <= push_words;
      tag_r[wr_ptr_r]   <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push_valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/c2p_back.sv =====
// ---------------------------------------------------------------------------
// c2p_back
// Walks the planes of the group at the queue head and sends one plane
// word per cycle through the output register while out_wd is ready.
// ---------------------------------------------------------------------------
module c2p_back import c2p_pkg::*; #(
  parameter int MAX_PLANES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              empty,
  input  logic [MAX_PLANES-1:0][WORD_W-1:0] head_words,
  input  c2p_tag_t                          head_tag,
  output logic                              pop,
  c2p_word_if.source                        out_wd
);

  localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  logic [PW-1:0] plane_r, plane_nxt;
  logic          valid_r, valid_nxt;
  logic [WORD_W-1:0]  word_r;
  logic [PLANE_W-1:0] num_r;
  logic [ROW_W-1:0]   row_r;
  logic [WPOS_W-1:0]  wpos_r;
  logic               last_r, done_r;
  logic can_load, load, is_last;

  assign can_load = !valid_r || out_wd.ready;
  assign load     = !empty && can_load;
  assign is_last  = PLANE_W'(plane_r) == head_tag.last_plane;
  assign pop      = load && is_last;

  always_comb begin
    plane_nxt = plane_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      plane_nxt = is_last ? '0 : plane_r + 1'b1;
    end else if (out_wd.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
      valid_r <= 1'b0;
    end else begin
      plane_r <= plane_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= head_words[plane_r];
      num_r  <= PLANE_W'(plane_r);
      row_r  <= head_tag.row;
      wpos_r <= head_tag.word;
      last_r <= is_last;
      done_r <= is_last && head_tag.frame_end;
    end
  end

  assign out_wd.valid         = valid_r;
  assign out_wd.plane_word    = word_r;
  assign out_wd.plane_number  = num_r;
  assign out_wd.row_number    = row_r;
  assign out_wd.word_in_row   = wpos_r;
  assign out_wd.last_of_group = last_r;
  assign out_wd.frame_done    = done_r;

endmodule

// ===== rtl/chunky_to_planar_encoder_top.sv =====
// ---------------------------------------------------------------------------
// chunky_to_planar_encoder_top
// Turns a raster stream of color indexes into 16-pixel bitplane words.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  in_px     sink       pixel_index, one word per pixel
//  out_wd    source     plane_word with plane, row, word position and flags
//  cfg_wr    sink       register index and write data
//
//  The front takes one pixel per cycle; each completed group queues one
//  entry, and the back sends its words at one per cycle while out_wd is
//  ready. A completing pixel waits while the two-entry group queue is
//  full; other pixels are taken regardless of output stalls. Sustained
//  rate is one pixel a cycle while groups average at least as many
//  pixels as there are planes. Reset restores register defaults and
//  clears accumulators and counters; a config write clears only those.
// ---------------------------------------------------------------------------
`include "chunky_to_planar_encoder_top_assert.svh"

module chunky_to_planar_encoder_top import c2p_pkg::*; #(
  parameter int MAX_PLANES = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  c2p_pixel_if.sink  in_px,
  c2p_word_if.source out_wd,
  c2p_cfg_if.sink    cfg_wr
);

  logic                              q_push, q_pop, q_full, q_empty;
  logic [MAX_PLANES-1:0][WORD_W-1:0] push_words, head_words;
  c2p_tag_t                          push_tag, head_tag;

  c2p_front #(
    .MAX_PLANES (MAX_PLANES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .cfg_wr     (cfg_wr),
    .q_full     (q_full),
    .push_valid (q_push),
    .push_words (push_words),
    .push_tag   (push_tag)
  );

  c2p_queue #(
    .MAX_PLANES (MAX_PLANES)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_words (push_words),
    .push_tag   (push_tag),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head_words (head_words),
    .head_tag   (head_tag)
  );

  c2p_back #(
    .MAX_PLANES (MAX_PLANES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (q_empty),
    .head_words (head_words),
    .head_tag   (head_tag),
    .pop        (q_pop),
    .out_wd     (out_wd)
  );

  // The front must never complete a group into a full queue.
  `C2P_ASSERT(a_no_overflow, clk, rst_n, !(q_push && q_full))
  `C2P_ASSERT(a_pop_nonempty, clk, rst_n, !(q_pop && q_empty))
  `C2P_ASSERT_NEXT(a_push_fills, clk, rst_n, q_push, !q_empty)
  `C2P_ASSERT_IMP(a_done_is_last, clk, rst_n, out_wd.valid && out_wd.frame_done, out_wd.last_of_group)

endmodule
